// File: rtl/bbct_pkg.sv
// ---------------------------------------------------------------------------
// bbct_pkg
// Shared types and constants for the bounding box corner transform block.
// ---------------------------------------------------------------------------
package bbct_pkg;

   // Coordinate and matrix element width (signed Q16.16)
   localparam int COORD_W     = 32;
   localparam int FRAC_BITS   = 16;

   // Configuration port
   localparam int CSR_W       = 64;
   localparam int NUM_CSR     = 6;
   localparam int CSR_IDX_W   = 3;

   // Emit queue and corner sequencing
   localparam int QUEUE_DEPTH = 2;
   localparam int NUM_CORNERS = 8;
   localparam int CORNER_W    = 3;

   // Datapath widths: product, three-term sum, shifted sum, sum plus translation
   localparam int PROD_W      = 2 * COORD_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int SHIFT_W     = SUM_W - FRAC_BITS;
   localparam int RES_W       = SHIFT_W + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [2:0]           vec3_type;   // index 0 x, 1 y, 2 z
   typedef coord_type [3:0]           mrow_type;   // three columns and translation
   typedef mrow_type  [2:0]           matrix_type;
   typedef logic [CSR_W-1:0]          csr_word_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [RES_W-1:0]   res_type;
   typedef logic [CORNER_W-1:0]       corner_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // Box snapshot carried from the front end to the corner engine
   typedef struct packed {
      vec3_type low;
      vec3_type high;
   } box_type;

   typedef struct packed {
      logic    valid;
      box_type box;
   } box_req_type;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_VERTEX  = 2'd0,
      OP_SET_BOX = 2'd1,
      OP_EMIT    = 2'd2
   } op_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_COLS01 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_COLS23 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_COLS01 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_COLS23 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_COLS01 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_COLS23 = 3'd5;

   // Identity matrix, no translation
   localparam csr_word_type CSR_RESET [NUM_CSR] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000
   };

endpackage

// File: rtl/bbct_ifs.sv
// ---------------------------------------------------------------------------
// bbct request and response channels
// Valid/ready channels carrying one request and one transformed corner.
// ---------------------------------------------------------------------------
interface bbct_req_if import bbct_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   coord_type  point_x;
   coord_type  point_y;
   coord_type  point_z;
   coord_type  upper_x;
   coord_type  upper_y;
   coord_type  upper_z;
   logic       final_vertex;

   modport source (
      output valid, opcode, point_x, point_y, point_z,
             upper_x, upper_y, upper_z, final_vertex,
      input  ready
   );
   modport sink (
      input  valid, opcode, point_x, point_y, point_z,
             upper_x, upper_y, upper_z, final_vertex,
      output ready
   );
endinterface

interface bbct_rsp_if import bbct_pkg::*; ();
   logic       valid;
   logic       ready;
   corner_type corner_index;
   coord_type  out_x;
   coord_type  out_y;
   coord_type  out_z;
   logic       end_of_run;

   modport source (
      output valid, corner_index, out_x, out_y, out_z, end_of_run,
      input  ready
   );
   modport sink (
      input  valid, corner_index, out_x, out_y, out_z, end_of_run,
      output ready
   );
endinterface

// File: rtl/bbct_front.sv
// ---------------------------------------------------------------------------
// bbct_front
// Takes requests, folds vertices into the running extremes, keeps the box
// and hands a box snapshot to the emit queue for each emit request.
// ---------------------------------------------------------------------------
module bbct_front import bbct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bbct_req_if.sink    req_ch,
   input  logic        queue_full,
   output box_req_type push
);

   vec3_type run_low_ff, run_high_ff;
   vec3_type run_low_in, run_high_in;
   box_type  box_ff;
   vec3_type point, upper;
   logic     accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign point = {req_ch.point_z, req_ch.point_y, req_ch.point_x};
   assign upper = {req_ch.upper_z, req_ch.upper_y, req_ch.upper_x};

   // Running extremes with the current vertex folded in
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         run_low_in[k]  = ($signed(point[k]) < $signed(run_low_ff[k]))
                          ? point[k] : run_low_ff[k];
         run_high_in[k] = ($signed(point[k]) > $signed(run_high_ff[k]))
                          ? point[k] : run_high_ff[k];
      end
   end

   // Running extremes and box state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_low_ff  <= {3{COORD_MAX}};
         run_high_ff <= {3{COORD_MIN}};
         box_ff      <= '0;
      end else if (accept) begin
         case (op_type'(req_ch.opcode))
            OP_VERTEX: begin
               if (req_ch.final_vertex) begin
                  box_ff.low  <= run_low_in;
                  box_ff.high <= run_high_in;
                  run_low_ff  <= {3{COORD_MAX}};
                  run_high_ff <= {3{COORD_MIN}};
               end else begin
                  run_low_ff  <= run_low_in;
                  run_high_ff <= run_high_in;
               end
            end
            OP_SET_BOX: begin
               // stored as given, no ordering check
               box_ff.low  <= point;
               box_ff.high <= upper;
            end
            default: ;
         endcase
      end
   end

   // Emit requests carry the box as it stands now
   assign push.valid = accept && (op_type'(req_ch.opcode) == OP_EMIT);
   assign push.box   = box_ff;

endmodule

// File: rtl/bbct_queue.sv
// ---------------------------------------------------------------------------
// bbct_queue
// Short FIFO of box snapshots between the front end and the corner engine.
// ---------------------------------------------------------------------------
module bbct_queue import bbct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  box_req_type push,
   input  logic        pop,
   output box_req_type head,
   output logic        full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   box_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.box   = entries_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push.box;
   end

endmodule

// File: rtl/bbct_back.sv
// ---------------------------------------------------------------------------
// bbct_back
// Corner engine: walks the eight corners of a queued box and runs each one
// through a multiply, sum and shift/saturate pipeline with a global stall.
// ---------------------------------------------------------------------------
module bbct_back import bbct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  box_req_type head,
   output logic        pop,
   input  matrix_type  matrix,
   bbct_rsp_if.source  rsp_ch
);

   // Sequencer
   logic       cmd_valid_ff;
   box_type    cmd_box_ff;
   corner_type corner_ff;

   // Pipeline
   logic       s1_valid_ff, s2_valid_ff, out_valid_ff;
   corner_type s1_idx_ff, s2_idx_ff, out_idx_ff;
   prod_type   prod_ff [3][3];
   prod_type   prod_in [3][3];
   sum_type    sum_ff  [3];
   coord_type  out_ff  [3];
   coord_type  sat_in  [3];
   vec3_type   corner;
   logic       advance, issue;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign issue   = cmd_valid_ff && advance;
   assign pop     = head.valid && !cmd_valid_ff;

   // Load a box, then step through its corners
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         corner_ff    <= '0;
      end else if (pop) begin
         cmd_valid_ff <= 1'b1;
         corner_ff    <= '0;
      end else if (issue) begin
         corner_ff <= corner_ff + 1'b1;
         if (corner_ff == CORNER_W'(NUM_CORNERS - 1)) cmd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cmd_box_ff <= head.box;
   end

   // Corner select and products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         corner[k] = corner_ff[k] ? cmd_box_ff.high[k] : cmd_box_ff.low[k];
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = prod_type'($signed(matrix[r][k]))
                          * prod_type'($signed(corner[k]));
         end
      end
   end

   // Shift, translate, saturate
   always_comb begin
      logic signed [SHIFT_W-1:0]     shifted;
      res_type                       res;
      logic [RES_W-COORD_W:0]        top;
      for (int r = 0; r < 3; r++) begin
         shifted = sum_ff[r][SUM_W-1:FRAC_BITS];
         res     = res_type'(shifted) + res_type'($signed(matrix[r][3]));
         top     = res[RES_W-1:COORD_W-1];
         if ((&top) || !(|top)) sat_in[r] = res[COORD_W-1:0];
         else if (res[RES_W-1]) sat_in[r] = COORD_MIN;
         else                   sat_in[r] = COORD_MAX;
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_idx_ff  <= corner_ff;
         s2_idx_ff  <= s1_idx_ff;
         out_idx_ff <= s2_idx_ff;
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) prod_ff[r][k] <= prod_in[r][k];
            sum_ff[r] <= sum_type'(prod_ff[r][0]) + sum_type'(prod_ff[r][1])
                       + sum_type'(prod_ff[r][2]);
            out_ff[r] <= sat_in[r];
         end
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.corner_index = out_idx_ff;
   assign rsp_ch.out_x        = out_ff[0];
   assign rsp_ch.out_y        = out_ff[1];
   assign rsp_ch.out_z        = out_ff[2];
   assign rsp_ch.end_of_run   = (out_idx_ff == CORNER_W'(NUM_CORNERS - 1));

endmodule

// File: rtl/bounding_box_corner_transform_core.sv
// ---------------------------------------------------------------------------
// bounding_box_corner_transform_core
// Axis-aligned bounding box with an affine transform of its eight corners.
// ---------------------------------------------------------------------------
// Vertex and set-box requests are taken one per cycle; ready only drops when
// two emit requests are already waiting. An emit request snapshots the box
// and queues it; the corner engine then sends its eight corners at one per
// cycle while the response side is ready, and loads the next box from the
// queue only after it has issued the last corner of the current one. Each
// corner goes through nine 32x32 multipliers, a three-term sum and a
// shift/translate/saturate stage; a stall on the response side freezes
// that pipeline as a whole.
// ---------------------------------------------------------------------------
module bounding_box_corner_transform_core import bbct_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   bbct_req_if.sink             req_ch,
   bbct_rsp_if.source           rsp_ch
);

   csr_word_type csr_ff [NUM_CSR];
   matrix_type   matrix;
   box_req_type  push, head;
   logic         queue_full, pop;

   // Matrix registers; writes beyond the last register are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) csr_ff[i] <= CSR_RESET[i];
      end else if (csr_we && (csr_index <= CSR_ROW2_COLS23)) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   // Unpack: low half is the even column, high half the odd one
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         matrix[r][0] = csr_ff[2*r][COORD_W-1:0];
         matrix[r][1] = csr_ff[2*r][CSR_W-1:COORD_W];
         matrix[r][2] = csr_ff[2*r+1][COORD_W-1:0];
         matrix[r][3] = csr_ff[2*r+1][CSR_W-1:COORD_W];
      end
   end

   bbct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   bbct_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   bbct_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .matrix (matrix),
      .rsp_ch (rsp_ch)
   );

   // No corner comes out straight after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   // Run marker sits on the last corner only
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         (rsp_ch.end_of_run == (rsp_ch.corner_index == CORNER_W'(NUM_CORNERS - 1))))
      else $error("end_of_run on wrong corner");

   // Corners of a run follow one another in order
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.end_of_run) ##1 rsp_ch.valid
      |-> (rsp_ch.corner_index == $past(rsp_ch.corner_index) + 3'd1))
      else $error("corner index out of sequence");

   // A pushed snapshot is never lost to a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !queue_full)
      else $error("emit request pushed into full queue");

endmodule

// File: tb/tb_bounding_box_corner_transform_core.sv
// ---------------------------------------------------------------------------
// tb_bounding_box_corner_transform_core
// Drives vertex, set-box and emit requests into the box transform core and
// checks every corner it returns against a cycle-free model of the box and
// the Q16.16 affine transform. Matrix settings change between traffic phases.
// ---------------------------------------------------------------------------
module tb_bounding_box_corner_transform_core;
   import bbct_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 70;

   // Opcode the block must drop without effect
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam coord_type Q_ZERO = '0;

   typedef csr_word_type csr_bank_type [NUM_CSR];

   typedef enum int {
      BANK_SHIFTED_IDENTITY,
      BANK_SMALL_RANDOM,
      BANK_ALL_MAX,
      BANK_ALL_MIN,
      BANK_ZERO,
      BANK_FULL_RANDOM
   } bank_style_type;

   typedef struct {
      logic [1:0] opcode;
      vec3_type   lo;      // point fields
      vec3_type   hi;      // upper fields
      logic       last;
   } bbox_cmd_type;

   typedef struct {
      bbox_cmd_type cmd;
      bit           pinned;   // every corner coordinate known up front
      coord_type    pin;
   } stim_row_type;

   typedef struct {
      corner_type idx;
      coord_type  x;
      coord_type  y;
      coord_type  z;
      logic       last;
   } corner_rec_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   bbct_req_if req_if ();
   bbct_rsp_if rsp_if ();

   bounding_box_corner_transform_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if)
   );

   // Model state
   csr_word_type mat_regs [NUM_CSR];
   coord_type    run_low  [3];
   coord_type    run_high [3];
   coord_type    box_lo   [3];
   coord_type    box_hi   [3];

   corner_rec_type corner_q [$];
   stim_row_type   directed_rows [$];

   int fail_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles_req;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------------
   function automatic void clear_running();
      for (int a = 0; a < 3; a++) begin
         run_low[a]  = COORD_MAX;
         run_high[a] = COORD_MIN;
      end
   endfunction

   // One output axis: floor((m0*x + m1*y + m2*z) / 2^FRAC) + t, saturated
   function automatic coord_type affine_row(input int row, input coord_type cx,
                                            input coord_type cy, input coord_type cz);
      coord_type m0, m1, m2, t;
      logic signed [71:0] acc, r, top, bottom;
      m0 = mat_regs[2*row][31:0];
      m1 = mat_regs[2*row][63:32];
      m2 = mat_regs[2*row+1][31:0];
      t  = mat_regs[2*row+1][63:32];
      top    = COORD_MAX;
      bottom = COORD_MIN;
      acc = m0 * cx + m1 * cy + m2 * cz;
      r   = (acc >>> FRAC_BITS) + t;
      if (r > top) r = top;
      if (r < bottom) r = bottom;
      return r[31:0];
   endfunction

   function automatic void apply_request(input bbox_cmd_type c, input bit pinned,
                                         input coord_type pin);
      coord_type      pt [3];
      corner_rec_type rec;
      for (int a = 0; a < 3; a++) pt[a] = $signed(c.lo[a]);
      case (c.opcode)
         OP_VERTEX: begin
            for (int a = 0; a < 3; a++) begin
               if (pt[a] < run_low[a])  run_low[a]  = pt[a];
               if (pt[a] > run_high[a]) run_high[a] = pt[a];
            end
            // last vertex is folded in before the commit
            if (c.last) begin
               box_lo = run_low;
               box_hi = run_high;
               clear_running();
            end
         end
         OP_SET_BOX: begin
            // stored as given, even when inverted
            for (int a = 0; a < 3; a++) begin
               box_lo[a] = pt[a];
               box_hi[a] = $signed(c.hi[a]);
            end
         end
         OP_EMIT: begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
               coord_type cv [3];
               for (int a = 0; a < 3; a++) cv[a] = i[a] ? box_hi[a] : box_lo[a];
               rec.idx  = corner_type'(i);
               rec.x    = pinned ? pin : affine_row(0, cv[0], cv[1], cv[2]);
               rec.y    = pinned ? pin : affine_row(1, cv[0], cv[1], cv[2]);
               rec.z    = pinned ? pin : affine_row(2, cv[0], cv[1], cv[2]);
               rec.last = (i == NUM_CORNERS - 1);
               corner_q.push_back(rec);
            end
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic coord_type pick_coord();
      case ($urandom_range(9))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return Q_ZERO;
         3, 4:    return $urandom;
         default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      endcase
   endfunction

   function automatic bbox_cmd_type rand_cmd(input logic [1:0] op, input logic last);
      bbox_cmd_type c;
      c.opcode = op;
      c.last   = last;
      for (int a = 0; a < 3; a++) begin
         c.lo[a] = pick_coord();
         c.hi[a] = pick_coord();
      end
      return c;
   endfunction

   function automatic stim_row_type stim_row(input logic [1:0] op, input coord_type px,
                                             input coord_type py, input coord_type pz,
                                             input coord_type ux, input coord_type uy,
                                             input coord_type uz, input logic last,
                                             input bit pinned, input coord_type pin);
      stim_row_type s;
      s.cmd.opcode = op;
      s.cmd.lo     = {pz, py, px};
      s.cmd.hi     = {uz, uy, ux};
      s.cmd.last   = last;
      s.pinned     = pinned;
      s.pin        = pin;
      return s;
   endfunction

   function automatic csr_bank_type make_bank(input bank_style_type style);
      csr_bank_type w;
      for (int i = 0; i < NUM_CSR; i++) begin
         case (style)
            BANK_SHIFTED_IDENTITY: begin
               w[i] = CSR_RESET[i];
               if (i % 2 == 1) w[i][63:32] = pick_coord();   // translation
            end
            BANK_SMALL_RANDOM:
               w[i] = {32'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000),
                       32'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000)};
            BANK_ALL_MAX:    w[i] = {COORD_MAX, COORD_MAX};
            BANK_ALL_MIN:    w[i] = {COORD_MIN, COORD_MIN};
            BANK_ZERO:       w[i] = '0;
            default:         w[i] = {$urandom, $urandom};
         endcase
      end
      return w;
   endfunction

   // Offer one request, with random idle cycles ahead of it
   task automatic offer(input bbox_cmd_type c, input bit pinned, input coord_type pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.opcode       <= c.opcode;
      req_if.point_x      <= c.lo[0];
      req_if.point_y      <= c.lo[1];
      req_if.point_z      <= c.lo[2];
      req_if.upper_x      <= c.hi[0];
      req_if.upper_y      <= c.hi[1];
      req_if.upper_z      <= c.hi[2];
      req_if.final_vertex <= c.last;
      do @(posedge clock); while (!req_if.ready);
      apply_request(c, pinned, pin);
   endtask

   // Sender goes quiet until every corner has come back, plus pipeline slack
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (corner_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write every matrix register, then one random index past the end
   task automatic load_matrix(input csr_bank_type w);
      int           bad_idx;
      csr_word_type junk;
      for (int i = 0; i < NUM_CSR; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= w[i];
         @(posedge clock);
         mat_regs[i] = w[i];
      end
      bad_idx = $urandom_range(NUM_CSR, (1 << CSR_IDX_W) - 1);
      junk    = {$urandom, $urandom};
      csr_index <= CSR_IDX_W'(bad_idx);
      csr_wdata <= junk;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed vertex sets and box loads followed by an emit
   task automatic random_traffic(input int budget);
      int issued, pick, n;
      issued = 0;
      while (issued < budget) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) offer(rand_cmd(OP_VERTEX, k == n - 1), 1'b0, Q_ZERO);
            issued += n;
            if ($urandom_range(99) < 85) begin
               offer(rand_cmd(OP_EMIT, $urandom_range(1)), 1'b0, Q_ZERO);
               issued++;
            end
         end else if (pick < 72) begin
            offer(rand_cmd(OP_SET_BOX, $urandom_range(1)), 1'b0, Q_ZERO);
            offer(rand_cmd(OP_EMIT, $urandom_range(1)), 1'b0, Q_ZERO);
            issued += 2;
         end else if (pick < 82) begin
            offer(rand_cmd(OP_EMIT, $urandom_range(1)), 1'b0, Q_ZERO);
            issued++;
         end else if (pick < 94) begin
            // stray vertex, may or may not close the set
            offer(rand_cmd(OP_VERTEX, $urandom_range(1)), 1'b0, Q_ZERO);
            issued++;
         end else begin
            offer(rand_cmd(OP_UNUSED, $urandom_range(1)), 1'b0, Q_ZERO);
         end
      end
   endtask

   task automatic run_phase(input bank_style_type style, input int s_pct, input int r_pct);
      load_matrix(make_bank(style));
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      random_traffic(PHASE_ITEMS);
      wait_drained();
   endtask

   function automatic void build_directed();
      // after reset the box is all zero
      directed_rows.push_back(stim_row(OP_EMIT, COORD_MAX, COORD_MIN, COORD_MAX,
                                       COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b1, Q_ZERO));
      // unknown opcode leaves the box alone
      directed_rows.push_back(stim_row(OP_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX,
                                       COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b1, Q_ZERO));
      // extremes through the identity matrix; marker on set-box is ignored
      directed_rows.push_back(stim_row(OP_SET_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                                       COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b1, COORD_MAX));
      directed_rows.push_back(stim_row(OP_SET_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                                       COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, COORD_MAX, COORD_MAX, COORD_MAX,
                                       COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1, COORD_MIN));
      // inverted box stored without a swap
      directed_rows.push_back(stim_row(OP_SET_BOX, 32'sh0005_0000, -32'sh0003_0000,
                                       32'sh0064_0000, -32'sh0005_0000, -32'sh0007_8000,
                                       Q_ZERO, 1'b0, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b0, Q_ZERO));
      // three-vertex set spanning the full range in x and y
      directed_rows.push_back(stim_row(OP_VERTEX, COORD_MAX, COORD_MIN, Q_ZERO,
                                       COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_VERTEX, COORD_MIN, COORD_MAX, -32'sd1,
                                       COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_VERTEX, 32'sh0001_8000, -32'sh0002_4000,
                                       COORD_MAX, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b0, Q_ZERO));
      // set of a single vertex
      directed_rows.push_back(stim_row(OP_VERTEX, -32'sd1, -32'sd1, -32'sd1,
                                       -32'sd1, -32'sd1, -32'sd1, 1'b1, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, -32'sd1, -32'sd1, -32'sd1,
                                       -32'sd1, -32'sd1, -32'sd1, 1'b0, 1'b0, Q_ZERO));
      // open set does not touch the box until its last vertex
      directed_rows.push_back(stim_row(OP_VERTEX, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_VERTEX, 32'sh0003_0000, 32'sh0004_0000,
                                       32'sh0005_0000, Q_ZERO, Q_ZERO, Q_ZERO,
                                       1'b1, 1'b0, Q_ZERO));
      directed_rows.push_back(stim_row(OP_EMIT, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b0, Q_ZERO));
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stalls, or a long hold-off when asked
   // ------------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles_req > 0) begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Corner checker
   always @(posedge clock) begin : check_corners
      corner_rec_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (corner_q.size() == 0) begin
            $error("corner %0d returned with no request outstanding", rsp_if.corner_index);
            fail_count++;
         end else begin
            want = corner_q.pop_front();
            if (rsp_if.corner_index !== want.idx) begin
               $error("corner_index: expected %0d, actual %0d", want.idx, rsp_if.corner_index);
               fail_count++;
            end
            if (rsp_if.out_x !== want.x) begin
               $error("out_x: expected %0d, actual %0d", want.x, rsp_if.out_x);
               fail_count++;
            end
            if (rsp_if.out_y !== want.y) begin
               $error("out_y: expected %0d, actual %0d", want.y, rsp_if.out_y);
               fail_count++;
            end
            if (rsp_if.out_z !== want.z) begin
               $error("out_z: expected %0d, actual %0d", want.z, rsp_if.out_z);
               fail_count++;
            end
            if (rsp_if.end_of_run !== want.last) begin
               $error("end_of_run: expected %0d, actual %0d", want.last, rsp_if.end_of_run);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      fail_count      = 0;
      hold_cycles_req = 0;
      send_idle_pct   = 26;
      recv_idle_pct   = 55;
      for (int i = 0; i < NUM_CSR; i++) mat_regs[i] = CSR_RESET[i];
      clear_running();
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = Q_ZERO;
         box_hi[a] = Q_ZERO;
      end

      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_if.valid        <= 1'b0;
      req_if.opcode       <= OP_VERTEX;
      req_if.point_x      <= '0;
      req_if.point_y      <= '0;
      req_if.point_z      <= '0;
      req_if.upper_x      <= '0;
      req_if.upper_y      <= '0;
      req_if.upper_z      <= '0;
      req_if.final_vertex <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset matrix
      build_directed();
      foreach (directed_rows[r])
         offer(directed_rows[r].cmd, directed_rows[r].pinned, directed_rows[r].pin);
      wait_drained();

      // Random traffic over several matrix settings and idle mixes
      run_phase(BANK_SHIFTED_IDENTITY, 26, 55);
      run_phase(BANK_ALL_MAX,          26, 55);
      run_phase(BANK_ALL_MIN,          55, 26);
      run_phase(BANK_ZERO,             55, 26);
      run_phase(BANK_FULL_RANDOM,       0,  0);
      run_phase(BANK_SMALL_RANDOM,      0,  0);

      // Back-pressure: hold the response side off while emits keep coming
      load_matrix(make_bank(BANK_FULL_RANDOM));
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      hold_cycles_req = HOLD_CYCLES;
      for (int k = 0; k < 12; k++) begin
         offer(rand_cmd(OP_SET_BOX, 1'b0), 1'b0, Q_ZERO);
         offer(rand_cmd(OP_EMIT, 1'b0), 1'b0, Q_ZERO);
      end
      wait_drained();

      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
